>>> sv/alin_pkg.sv
// ----------------------------------------------------------------------------
// alin_pkg: shared types and constants for the ADC table linearizer
// Holds field widths, request and status codes, the pin map and the
// status structure of the iterative divider.
// ----------------------------------------------------------------------------
package alin_pkg;

  localparam int IDX_W  = 8;
  localparam int VAL_W  = 12;
  localparam int PIN_W  = 8;
  localparam int OUT_W  = 12;
  localparam int STAT_W = 2;

  typedef logic [STAT_W-1:0] status_t;

  localparam logic    REQ_WRITE   = 1'b0;
  localparam logic    REQ_CONVERT = 1'b1;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_BAD_PIN = 2'd1;
  localparam status_t ST_NO_BIN  = 2'd2;
  localparam status_t ST_UNUSED  = 2'd3;

  typedef struct packed {
    logic hit;
    logic tbl;
  } pin_map_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic pin_map_t pin_lookup(input logic [PIN_W-1:0] pin);
    pin_map_t m;
    m.hit = 1'b0;
    m.tbl = 1'b0;
    if (pin >= 8'd32 && pin <= 8'd39) begin
      m.hit = 1'b1;
    end else if (pin == 8'd0 || pin == 8'd2 || pin == 8'd4 ||
                 (pin >= 8'd12 && pin <= 8'd15) ||
                 (pin >= 8'd25 && pin <= 8'd27)) begin
      m.hit = 1'b1;
      m.tbl = 1'b1;
    end
    return m;
  endfunction

endpackage

>>> sv/alin_mem.sv
// ----------------------------------------------------------------------------
// alin_mem: calibration table storage
// Single write port and one registered read port holding the measured
// codes of all tables, one table after the other.
// ----------------------------------------------------------------------------
module alin_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/alin_div.sv
// ----------------------------------------------------------------------------
// alin_div: iterative restoring divider
// Produces one quotient bit per cycle with a single shared subtractor and
// raises done for one cycle when the quotient is complete.
// ----------------------------------------------------------------------------
module alin_div
  import alin_pkg::*;
#(
  parameter int NW = 48,
  parameter int DW = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output div_sts_t      sts
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
    quo_nxt = {quo_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo      = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

>>> sv/adc_table_linearizer.sv
// ----------------------------------------------------------------------------
// adc_table_linearizer: piecewise linear ADC code correction
// Loads measured calibration tables and converts raw codes by locating the
// matching bin and interpolating with an exact rounded division.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_      input      write entry or convert request, valid/ready
//  out_     output     corrected code and status, valid/ready
//
//  A write transaction is accepted and produces no result.
//  A convert on a bad pin goes from acceptance to the done state and then to
//  the output register. Otherwise the scan reads one entry per cycle until a
//  bin matches or the last bin is reached; then products and sums are
//  registered, the bit-serial divider runs and the result is registered.
//  Reset is synchronous; table contents are undefined until written.
//  A held result stalls only the end of the next convert, not its acceptance.
// ----------------------------------------------------------------------------
module adc_table_linearizer
  import alin_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int NUM_TABLES    = 2,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req_type,
  input  logic             in_table_sel,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic [VAL_W-1:0] in_entry_value,
  input  logic [PIN_W-1:0] in_pin_number,
  input  logic [VAL_W-1:0] in_raw_code,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_corrected_code,
  output status_t          out_status
);

  localparam int SB     = SAMPLE_BITS;
  localparam int XW     = (SB > VAL_W) ? SB : VAL_W;
  localparam int IW     = $clog2(TABLE_ENTRIES);
  localparam int DEPTH  = NUM_TABLES * TABLE_ENTRIES;
  localparam int AW     = $clog2(DEPTH);
  localparam int CODE_M = (1 << SB) - 1;
  localparam int SPAN   = TABLE_ENTRIES - 1;
  localparam int STEP   = (2 * CODE_M + SPAN) / (2 * SPAN);
  localparam int SSW    = SB + 2;
  localparam int PW     = IW + SB;
  localparam int QW     = 2 * SB;
  localparam int NUMW   = 2 * SB + IW + 2;
  localparam int DENW   = IW + SB;
  localparam int NW     = NUMW + 1;
  localparam int DW     = DENW + 1;

  localparam logic [SB-1:0]   CODE_MAX  = SB'(CODE_M);
  localparam logic [SSW-1:0]  STEP_SPAN = SSW'(STEP * SPAN);
  localparam logic [DENW-1:0] SPAN_C    = DENW'(SPAN);
  localparam logic [IW-1:0]   LAST_BIN  = IW'(TABLE_ENTRIES - 2);
  localparam logic [AW-1:0]   TBL1_BASE = AW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_MUL,
    S_SUM,
    S_DIVGO,
    S_DIV,
    S_DONE
  } state_t;

  state_t          state_r;
  logic            tbl_r;
  logic [SB-1:0]   raw_r;
  logic [SB-1:0]   lo_r;
  logic [IW-1:0]   idx_r;
  logic [SB-1:0]   bin_r;
  logic [SB-1:0]   diff_r;
  logic [PW-1:0]   prod_r;
  logic [QW-1:0]   stepd_r;
  logic [NUMW-1:0] num_r;
  logic [DENW-1:0] den_r;
  logic [SB-1:0]   res_code_r;
  status_t         res_stat_r;
  logic            out_valid_r;
  logic [OUT_W-1:0] out_code_r;
  status_t         out_stat_r;

  logic            in_fire;
  logic            out_take;
  logic            out_load;
  pin_map_t        pmap;
  logic            pin_ok;
  logic [SB-1:0]   raw_in;
  logic [SB-1:0]   val_in;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [SB-1:0]   rd_data;
  logic [AW-1:0]   base;
  logic [SB-1:0]   hi;
  logic            match;
  logic            div_start;
  logic [NW-1:0]   div_num;
  logic [DW-1:0]   div_den;
  logic [NW-1:0]   div_quo;
  div_sts_t        div_sts;
  logic [SB-1:0]   quo_sat;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    pmap    = pin_lookup(in_pin_number);
    pin_ok  = pmap.hit && (int'(pmap.tbl) < NUM_TABLES);
    raw_in  = SB'(XW'(in_raw_code) & XW'(CODE_MAX));
    val_in  = SB'(XW'(in_entry_value) & XW'(CODE_MAX));
    wr_en   = in_fire && (in_req_type == REQ_WRITE) &&
              (int'(in_table_sel) < NUM_TABLES) &&
              (int'(in_entry_index) < TABLE_ENTRIES);
    wr_addr = (in_table_sel ? TBL1_BASE : '0) + AW'(in_entry_index);
    base    = tbl_r ? TBL1_BASE : '0;
    hi      = rd_data;
    match   = (raw_r >= lo_r) && (raw_r < hi);
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_r)
      S_IDLE: begin
        rd_en   = in_fire && (in_req_type == REQ_CONVERT) && pin_ok;
        rd_addr = pmap.tbl ? TBL1_BASE : '0;
      end
      S_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = base + AW'(1);
      end
      S_SCAN: begin
        rd_en   = !match && (idx_r != LAST_BIN);
        rd_addr = base + AW'(idx_r) + AW'(2);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
    div_start = (state_r == S_DIVGO);
    div_num   = {num_r, 1'b0} + NW'(den_r);
    div_den   = {den_r, 1'b0};
    quo_sat   = (div_quo > NW'(CODE_MAX)) ? CODE_MAX : div_quo[SB-1:0];
  end

  alin_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (SB)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  alin_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .sts   (div_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && (in_req_type == REQ_CONVERT)) begin
            raw_r <= raw_in;
            tbl_r <= pmap.tbl;
            if (pin_ok) begin
              state_r <= S_FIRST;
            end else begin
              res_code_r <= '0;
              res_stat_r <= ST_BAD_PIN;
              state_r    <= S_DONE;
            end
          end
        end
        S_FIRST: begin
          lo_r    <= rd_data;
          idx_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (match) begin
            bin_r   <= hi - lo_r;
            diff_r  <= raw_r - lo_r;
            state_r <= S_MUL;
          end else if (idx_r == LAST_BIN) begin
            res_code_r <= CODE_MAX;
            res_stat_r <= ST_NO_BIN;
            state_r    <= S_DONE;
          end else begin
            lo_r  <= hi;
            idx_r <= idx_r + 1'b1;
          end
        end
        S_MUL: begin
          prod_r  <= PW'(idx_r) * PW'(bin_r);
          stepd_r <= QW'(STEP_SPAN) * QW'(diff_r);
          den_r   <= SPAN_C * DENW'(bin_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          num_r   <= (NUMW'(prod_r) << SB) - NUMW'(prod_r) + NUMW'(stepd_r);
          state_r <= S_DIVGO;
        end
        S_DIVGO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_sts.done) begin
            res_code_r <= quo_sat;
            res_stat_r <= ST_OK;
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_code_r  <= OUT_W'(res_code_r);
            out_stat_r  <= res_stat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_corrected_code = out_code_r;
  assign out_status         = out_stat_r;

  a_write_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_req_type == REQ_WRITE)) |=> (state_r == S_IDLE))
    else $error("write transaction started a conversion");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= LAST_BIN))
    else $error("bin index ran past the last bin");

  a_bad_pin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r == ST_BAD_PIN)) |-> (out_code_r == '0))
    else $error("bad pin result is not zero");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_stat_r != ST_UNUSED))
    else $error("unused status code driven");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> (state_r == S_DIV))
    else $error("divider busy outside the divide state");

endmodule
